/* design/mcqs_pkg.sv */
// ----------------------------------------------------------------------------
// Motor command queue sequencer package
// Shared sizes, codes, entry layout and helper functions.
// ----------------------------------------------------------------------------
package mcqs_pkg;

	localparam int QUEUE_SLOTS = 4;
	localparam int MOTOR_SLOTS = 8;
	localparam int QW          = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int CODE_W      = 6;
	localparam int TICK_W      = 17;
	localparam int PERIOD_W    = 16;
	localparam int CMD_W       = 48;
	localparam int NUM_W       = 18;   // widest delay plus period minus one

	localparam logic [TICK_W-1:0]   START_DELAY_US   = 17'd10000;
	localparam logic [TICK_W-1:0]   REPEAT_DELAY_US  = 17'd1000;
	localparam logic [TICK_W-1:0]   LONG_POST_US     = 17'd100000;
	localparam logic [3:0]          SETTINGS_REPEATS = 4'd10;
	localparam logic [3:0]          SINGLE_REPEAT    = 4'd1;
	localparam logic [3:0]          ALL_TARGET       = 4'd8;
	localparam logic [CODE_W-1:0]   MAX_CODE         = 6'd47;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd125;

	// request kinds carried in tuser
	localparam logic REQ_ENQUEUE = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	// register index of loop_period_us
	localparam logic [2:0] REG_LOOP_PERIOD = 3'd0;

	// tick table selectors
	localparam logic [1:0] TAB_START  = 2'd0;
	localparam logic [1:0] TAB_REPEAT = 2'd1;
	localparam logic [1:0] TAB_LONG   = 2'd2;

	typedef logic [QW-1:0] qidx_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_ACTIVE,
		PH_POST
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [TICK_W-1:0]   delay;
		logic [3:0]          reps;
		logic                long_post;
	} entry_t;

	typedef struct packed {
		logic [TICK_W-1:0] start_ticks;
		logic [TICK_W-1:0] repeat_ticks;
		logic [TICK_W-1:0] long_ticks;
		logic              busy;
	} tick_tab_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN
	} div_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_EXEC,
		SQ_FETCH,
		SQ_OUT
	} seq_state_t;

	function automatic qidx_t next_slot(qidx_t s);
		qidx_t r;
		if (s == qidx_t'(QUEUE_SLOTS - 1)) r = '0;
		else r = s + qidx_t'(1);
		return r;
	endfunction

	function automatic logic [3:0] repeat_count(logic [CODE_W-1:0] code);
		logic [3:0] r;
		if (code inside {6'd7, 6'd8, 6'd9, 6'd10, 6'd12, 6'd13, 6'd14, 6'd20, 6'd21})
			r = SETTINGS_REPEATS;
		else
			r = SINGLE_REPEAT;
		return r;
	endfunction

	function automatic logic has_long_post(logic [CODE_W-1:0] code);
		return (code inside {[6'd1:6'd5]});
	endfunction

endpackage

/* design/mcqs_ticks.sv */
// ----------------------------------------------------------------------------
// Tick table unit
// Converts the fixed delays to loop ticks by ceiling division by the period,
// one quotient bit per cycle, after reset and after each period write.
// ----------------------------------------------------------------------------
module mcqs_ticks import mcqs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PERIOD_W-1:0] period,
	output tick_tab_t           tab
);

	div_state_t          state_q, state_d;
	logic [1:0]          sel_q;
	logic [4:0]          cnt_q;
	logic [NUM_W-1:0]    num_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] div_q;
	logic [TICK_W-1:0]   quo_q;
	logic [TICK_W-1:0]   start_ticks_q, repeat_ticks_q, long_ticks_q;

	logic [PERIOD_W-1:0] p_eff;
	logic [TICK_W-1:0]   us_sel;
	logic [NUM_W-1:0]    dividend;
	logic [PERIOD_W:0]   trial;
	logic                fits;
	logic [TICK_W-1:0]   result;
	logic                last_step;

	always_comb begin
		p_eff = (period == '0) ? PERIOD_W'(1) : period;
		case (sel_q)
			TAB_REPEAT: us_sel = REPEAT_DELAY_US;
			TAB_LONG:   us_sel = LONG_POST_US;
			default:    us_sel = START_DELAY_US;
		endcase
		dividend  = {1'b0, us_sel} + NUM_W'(p_eff) - NUM_W'(1);
		trial     = {rem_q, num_q[NUM_W-1]};
		fits      = (trial >= {1'b0, div_q});
		result    = {quo_q[TICK_W-2:0], fits};
		last_step = (cnt_q == 5'(NUM_W - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: state_d = DIV_IDLE;
			DIV_LOAD: state_d = DIV_RUN;
			DIV_RUN: begin
				if (last_step) state_d = (sel_q == TAB_LONG) ? DIV_IDLE : DIV_LOAD;
			end
			default: state_d = DIV_IDLE;
		endcase
		if (start) state_d = DIV_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_LOAD;
			sel_q   <= TAB_START;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				sel_q <= TAB_START;
			end else if (state_q == DIV_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q + 5'd1;
				if (last_step) sel_q <= sel_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_LOAD) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= p_eff;
			quo_q <= '0;
		end else if (state_q == DIV_RUN) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? PERIOD_W'(trial - {1'b0, div_q}) : trial[PERIOD_W-1:0];
			quo_q <= result;
			if (last_step) begin
				case (sel_q)
					TAB_START:  start_ticks_q  <= result;
					TAB_REPEAT: repeat_ticks_q <= result;
					TAB_LONG:   long_ticks_q   <= result;
					default:    ;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		tab.start_ticks  = start_ticks_q;
		tab.repeat_ticks = repeat_ticks_q;
		tab.long_ticks   = long_ticks_q;
		tab.busy         = (state_q != DIV_IDLE);
	end

endmodule

/* design/motor_command_queue_sequencer.sv */
// ----------------------------------------------------------------------------
// Motor command queue sequencer
// Ring queue of motor commands kept in two small synchronous memories,
// advanced by loop ticks and filled by enqueue requests.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_axis    in         one request item: enqueue (tuser 0) or loop tick (tuser 1)
// m_axis    out        one result item per request
// apb       in/out     loop_period_us at byte address 0
//
// Steps: a request passes accept, read-modify-write of the entry memory,
// read back of the tail entry and result load, in that order; the result
// load also waits while the result register waits on m_axis_tready.
// Reset and each loop_period_us write start the tick table unit, which runs
// three ceiling divisions, one after another; s_axis_tready stays low
// meanwhile. The output register lets a finished result wait while the next
// request is accepted.
//
module motor_command_queue_sequencer import mcqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] target_motor, [9:4] command_code, [13:10] motor_count,
	// [14] motors_idle, [15] commands_enabled
	input  logic [15:0] s_axis_tdata,
	// [0] req_type
	input  logic        s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] output_enabled, [1] accepted, [2] processing, [3] queue_empty,
	// [51:4] motor_commands, [55:52] zero
	output logic [55:0] m_axis_tdata
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] period_q;
	logic                cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr == REG_LOOP_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && cfg_hit) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	assign prdata = cfg_hit ? {16'd0, period_q} : 32'd0;

	// ------------------------------------------------------------------
	// Tick table: delays in loop ticks for the current period
	// ------------------------------------------------------------------
	tick_tab_t tab;

	mcqs_ticks u_ticks (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (psel && penable && pwrite && cfg_hit),
		.period (period_q),
		.tab    (tab)
	);

	// ------------------------------------------------------------------
	// Sequencer control
	// ------------------------------------------------------------------
	seq_state_t state_q, state_d;
	logic       in_take;
	logic       exec_en;
	logic       out_free;
	logic       out_load;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign in_take  = s_axis_tvalid && s_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE:  if (in_take) state_d = SQ_EXEC;
			SQ_EXEC:  state_d = SQ_FETCH;
			SQ_FETCH: state_d = SQ_OUT;
			SQ_OUT:   if (out_free) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = (state_q == SQ_IDLE) && !tab.busy;
		exec_en       = (state_q == SQ_EXEC);
		out_load      = (state_q == SQ_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SQ_IDLE;
		else state_q <= state_d;
	end

	// hold the accepted item
	logic                req_q;
	logic [3:0]          target_q;
	logic [CODE_W-1:0]   code_q;
	logic [3:0]          count_q;
	logic                idle_q;
	logic                cmd_en_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q    <= s_axis_tuser;
			target_q <= s_axis_tdata[3:0];
			code_q   <= s_axis_tdata[9:4];
			count_q  <= s_axis_tdata[13:10];
			idle_q   <= s_axis_tdata[14];
			cmd_en_q <= s_axis_tdata[15];
		end
	end

	// ------------------------------------------------------------------
	// Queue pointers and memories
	// ------------------------------------------------------------------
	qidx_t head_q, tail_q, head_d, tail_d;

	entry_t ctrl_mem [QUEUE_SLOTS];
	entry_t ctrl_rd_q;
	logic [MOTOR_SLOTS-1:0][CODE_W-1:0] cmd_mem [QUEUE_SLOTS];
	logic [MOTOR_SLOTS-1:0][CODE_W-1:0] cmd_rd_q;
	logic [QUEUE_SLOTS-1:0][MOTOR_SLOTS-1:0] cmd_vld_q;
	logic [MOTOR_SLOTS-1:0] vld_rd_q;

	// write side, filled by the execute step
	qidx_t                              wr_addr;
	entry_t                             wr_entry;
	logic                               tmr_we, attr_we;
	logic [MOTOR_SLOTS-1:0]             cmd_we;
	logic [MOTOR_SLOTS-1:0][CODE_W-1:0] cmd_wdata;
	logic                               outen_d, acc_d;
	logic                               outen_q, acc_q;

	// execute: read-modify-write of the entry at the tail or the head
	always_comb begin
		logic              empty, last;
		logic [3:0]        reps_left;
		logic [TICK_W-1:0] post_ticks;

		empty      = (head_q == tail_q);
		last       = (next_slot(tail_q) == head_q);
		reps_left  = (ctrl_rd_q.reps != 4'd0) ? ctrl_rd_q.reps - 4'd1 : 4'd0;
		post_ticks = ctrl_rd_q.long_post ? tab.long_ticks : tab.repeat_ticks;
		if (!last && post_ticks != '0) post_ticks = post_ticks - TICK_W'(1);

		head_d    = head_q;
		tail_d    = tail_q;
		wr_addr   = tail_q;
		wr_entry  = ctrl_rd_q;
		tmr_we    = 1'b0;
		attr_we   = 1'b0;
		cmd_we    = '0;
		cmd_wdata = '0;
		outen_d   = 1'b0;
		acc_d     = 1'b0;

		if (req_q == REQ_ENQUEUE) begin
			if (cmd_en_q && code_q <= MAX_CODE && next_slot(head_q) != tail_q) begin
				acc_d              = 1'b1;
				wr_addr            = head_q;
				head_d             = next_slot(head_q);
				tmr_we             = 1'b1;
				attr_we            = 1'b1;
				wr_entry.reps      = repeat_count(code_q);
				wr_entry.long_post = has_long_post(code_q);
				wr_entry.phase     = idle_q ? PH_START : PH_IDLE;
				wr_entry.delay     = idle_q ? tab.start_ticks : '0;
				for (int m = 0; m < MOTOR_SLOTS; m++) begin
					if (4'(m) < count_q) begin
						cmd_we[m] = 1'b1;
						cmd_wdata[m] = (4'(m) == target_q || target_q == ALL_TARGET)
							? code_q : '0;
					end
				end
			end
		end else if (empty) begin
			outen_d = 1'b1;
		end else begin
			case (ctrl_rd_q.phase)
				PH_IDLE: begin
					outen_d = 1'b1;
					if (idle_q) begin
						tmr_we         = 1'b1;
						wr_entry.phase = PH_START;
						wr_entry.delay = tab.start_ticks;
					end
				end
				PH_START, PH_ACTIVE: begin
					tmr_we  = 1'b1;
					attr_we = 1'b1;
					if (ctrl_rd_q.delay != '0) begin
						// count down the start delay or the gap between repeats
						wr_entry.delay = ctrl_rd_q.delay - TICK_W'(1);
					end else begin
						outen_d       = 1'b1;
						wr_entry.reps = reps_left;
						if (reps_left != 4'd0) begin
							wr_entry.phase = PH_ACTIVE;
							wr_entry.delay = tab.repeat_ticks;
						end else begin
							wr_entry.phase = PH_POST;
							wr_entry.delay = post_ticks;
						end
					end
				end
				default: begin
					if (ctrl_rd_q.delay != '0) begin
						tmr_we         = 1'b1;
						wr_entry.delay = ctrl_rd_q.delay - TICK_W'(1);
					end else begin
						// retire the entry; the next one goes straight to active
						tail_d = next_slot(tail_q);
						if (tail_d != head_q) begin
							wr_addr        = tail_d;
							tmr_we         = 1'b1;
							wr_entry.phase = PH_ACTIVE;
							wr_entry.delay = '0;
						end else begin
							outen_d = 1'b1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cmd_vld_q <= '0;
		end else if (exec_en) begin
			head_q <= head_d;
			tail_q <= tail_d;
			for (int m = 0; m < MOTOR_SLOTS; m++) begin
				if (cmd_we[m]) cmd_vld_q[wr_addr][m] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			outen_q <= outen_d;
			acc_q   <= acc_d;
		end
	end

	// entry memory: timer and attribute fields written separately
	always_ff @(posedge clk) begin
		if (exec_en && tmr_we) begin
			ctrl_mem[wr_addr].phase <= wr_entry.phase;
			ctrl_mem[wr_addr].delay <= wr_entry.delay;
		end
		if (exec_en && attr_we) begin
			ctrl_mem[wr_addr].reps      <= wr_entry.reps;
			ctrl_mem[wr_addr].long_post <= wr_entry.long_post;
		end
		ctrl_rd_q <= ctrl_mem[tail_q];
	end

	// command memory: one write lane per motor slot
	always_ff @(posedge clk) begin
		for (int m = 0; m < MOTOR_SLOTS; m++) begin
			if (exec_en && cmd_we[m]) cmd_mem[wr_addr][m] <= cmd_wdata[m];
		end
		cmd_rd_q <= cmd_mem[tail_q];
		vld_rd_q <= cmd_vld_q[tail_q];
	end

	// ------------------------------------------------------------------
	// Result: status of the tail entry after the request
	// ------------------------------------------------------------------
	logic [55:0] result;

	always_comb begin
		logic             empty, last, proc;
		logic [CMD_W-1:0] cmds;

		empty = (head_q == tail_q);
		last  = (next_slot(tail_q) == head_q);
		proc  = !empty && (ctrl_rd_q.phase == PH_START || ctrl_rd_q.phase == PH_ACTIVE
			|| (ctrl_rd_q.phase == PH_POST && !last));
		cmds  = '0;
		for (int m = 0; m < MOTOR_SLOTS; m++) begin
			// unwritten slots read as stop
			if (!empty && vld_rd_q[m]) cmds[m*CODE_W +: CODE_W] = cmd_rd_q[m];
		end
		result = {4'd0, cmds, empty, proc, acc_q, outen_q};
	end

	logic        out_valid_q;
	logic [55:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	a_no_take_while_table_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tab.busy |-> !s_axis_tready)
		else $error("request taken while tick table is being computed");

	a_take_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == SQ_EXEC)
		else $error("accepted request did not enter execute");

	a_processing_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[2] && out_data_q[3]))
		else $error("result shows processing on an empty queue");

	a_one_pointer_step: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_en |=> $stable(head_q) && $stable(tail_q))
		else $error("queue pointer moved outside execute");
`endif

endmodule
